[hdl/qau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Types, constants and helper functions shared by the quaternion unit files.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int DW      = 32;
	localparam int FW      = 28;
	localparam int PW      = 2 * DW;
	localparam int AW      = PW + 2;
	localparam int SW      = PW + 1;
	localparam int QRW     = PW + 2;
	localparam int NRW     = DW + 1;
	localparam int SQ_STEPS = NRW;
	localparam int QW      = FW + 1;
	localparam int NW      = DW + QW;
	localparam int DDW     = NRW + 1;
	localparam int RW      = DDW + QW - 1;

	localparam int S_SQ0 = 3;
	localparam int S_PR  = S_SQ0 + SQ_STEPS + 1;
	localparam int LAT   = S_PR + QW + 1;

	typedef enum logic [2:0] {
		MODE_CONJ  = 3'd0,
		MODE_MUL   = 3'd1,
		MODE_SCALE = 3'd2,
		MODE_ADD   = 3'd3,
		MODE_NORM  = 3'd4
	} mode_t;

	typedef logic signed [DW-1:0] fix_t;

	typedef struct packed {
		logic       norm;
		logic       zero;
		logic       ovf;
		fix_t [3:0] r;
	} pay_t;

	typedef struct packed {
		logic ovf;
		fix_t val;
	} sat_t;

	localparam logic [1:0] BSEL [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};
	localparam bit BNEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0}
	};

	localparam logic signed [AW-1:0] MAXV = $signed({{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}});
	localparam logic signed [AW-1:0] MINV = $signed({{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}});
	localparam logic signed [AW-1:0] RND  = $signed(AW'(1) << (FW - 1));
	localparam fix_t ONE = $signed(DW'(1) << FW);

	function automatic sat_t sat_wide(input logic signed [AW-1:0] v);
		sat_t s;
		s.ovf = 1'b0;
		s.val = v[DW-1:0];
		if (v > MAXV) begin
			s.val = {1'b0, {(DW-1){1'b1}}};
			s.ovf = 1'b1;
		end else if (v < MINV) begin
			s.val = {1'b1, {(DW-1){1'b0}}};
			s.ovf = 1'b1;
		end
		return s;
	endfunction

endpackage

[hdl/qau_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion unit command channel
// Valid/ready channel carrying one operation with its operands.
// ----------------------------------------------------------------------------
interface qau_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	qau_pkg::fix_t a_w;
	qau_pkg::fix_t a_x;
	qau_pkg::fix_t a_y;
	qau_pkg::fix_t a_z;
	qau_pkg::fix_t b_w;
	qau_pkg::fix_t b_x;
	qau_pkg::fix_t b_y;
	qau_pkg::fix_t b_z;
	qau_pkg::fix_t scale_factor;

	modport source (output valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		scale_factor, input ready);
	modport sink (input valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		scale_factor, output ready);
endinterface

[hdl/qau_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion unit result channel
// Valid/ready channel carrying one result quaternion and its flags.
// ----------------------------------------------------------------------------
interface qau_out_if;
	logic          valid;
	logic          ready;
	qau_pkg::fix_t r_w;
	qau_pkg::fix_t r_x;
	qau_pkg::fix_t r_y;
	qau_pkg::fix_t r_z;
	logic          overflow;
	logic          zero_norm;

	modport source (output valid, r_w, r_x, r_y, r_z, overflow, zero_norm, input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, overflow, zero_norm, output ready);
endinterface

[hdl/quaternion_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Conjugate, Hamilton product, scaling, addition and normalisation of Q3.28
// quaternions in one stall-able pipeline.
//
//   channel | role | content
//   cmd     | in   | mode, quaternions a and b, scale_factor
//   rsp     | out  | r_w..r_z, overflow, zero_norm
//
// One transaction enters per cycle while rsp does not stall.
// The depth is set by the square root (33 steps) and the divider (29 steps).
// Reset clears only the valid bits of the stages.
// While rsp stalls the whole pipeline holds and cmd.ready is low.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
	input logic     clk,
	input logic     arst_n,
	qau_in_if.sink   cmd,
	qau_out_if.source rsp
);

	logic                  en;
	logic [qau_pkg::LAT:1] vld_s;

	qau_pkg::mode_t               mode_s1;
	logic signed [qau_pkg::PW-1:0] prod_s1 [4][4];
	logic signed [qau_pkg::DW:0]   lin_s1 [4];
	qau_pkg::fix_t                a_s1 [4];

	qau_pkg::mode_t               mode_s2;
	logic signed [qau_pkg::AW-1:0] acc_s2 [4];
	logic [qau_pkg::SW-1:0]        sumsq_s2;
	qau_pkg::fix_t                a_s2 [4];

	qau_pkg::pay_t          pay_s  [qau_pkg::S_SQ0:qau_pkg::LAT-1];
	logic [qau_pkg::QRW-1:0] rem_s  [qau_pkg::S_SQ0:qau_pkg::S_PR-1];
	logic [qau_pkg::QRW-1:0] root_s [qau_pkg::S_SQ0:qau_pkg::S_PR-1];
	logic [qau_pkg::DDW-1:0] den_s  [qau_pkg::S_PR:qau_pkg::LAT-1];
	logic [qau_pkg::NW-1:0]  num_s  [qau_pkg::S_PR:qau_pkg::LAT-1][4];
	logic [qau_pkg::QW-1:0]  qt_s   [qau_pkg::S_PR:qau_pkg::LAT-1][4];
	qau_pkg::pay_t          out_s67;

	qau_pkg::fix_t                 a_c [4];
	qau_pkg::fix_t                 b_c [4];
	qau_pkg::fix_t                 d_c [4];
	logic signed [qau_pkg::DW:0]   lin_c [4];
	logic signed [qau_pkg::AW-1:0] acc_c [4];
	logic [qau_pkg::SW-1:0]        sumsq_c;
	qau_pkg::pay_t                 pay_c;
	logic signed [qau_pkg::AW-1:0] rv_c;
	qau_pkg::sat_t                 st_c;
	logic [qau_pkg::NRW-1:0]       n_c;
	logic [qau_pkg::DW-1:0]        mag_c [4];
	qau_pkg::pay_t                 out_c;

	assign en        = !vld_s[qau_pkg::LAT] || rsp.ready;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[qau_pkg::LAT-1:1], cmd.valid};
		end
	end

	// Stage 1: all sixteen products; the diagonal is shared by multiply, scale and normalise.
	always_comb begin
		a_c[0] = cmd.a_w; a_c[1] = cmd.a_x; a_c[2] = cmd.a_y; a_c[3] = cmd.a_z;
		b_c[0] = cmd.b_w; b_c[1] = cmd.b_x; b_c[2] = cmd.b_y; b_c[3] = cmd.b_z;
		for (int k = 0; k < 4; k++) begin
			case (qau_pkg::mode_t'(cmd.mode))
				qau_pkg::MODE_SCALE: d_c[k] = cmd.scale_factor;
				qau_pkg::MODE_NORM:  d_c[k] = a_c[k];
				default:             d_c[k] = b_c[k];
			endcase
			case (qau_pkg::mode_t'(cmd.mode))
				qau_pkg::MODE_CONJ: lin_c[k] = (k == 0) ? (qau_pkg::DW+1)'(a_c[k])
					: -(qau_pkg::DW+1)'(a_c[k]);
				qau_pkg::MODE_ADD:  lin_c[k] = (qau_pkg::DW+1)'(a_c[k])
					+ (qau_pkg::DW+1)'(b_c[k]);
				default:            lin_c[k] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= qau_pkg::mode_t'(cmd.mode);
			for (int t = 0; t < 4; t++) begin
				a_s1[t]   <= a_c[t];
				lin_s1[t] <= lin_c[t];
				for (int j = 0; j < 4; j++) begin
					prod_s1[t][j] <= qau_pkg::PW'(a_c[t])
						* qau_pkg::PW'((t == j) ? d_c[t] : b_c[j]);
				end
			end
		end
	end

	// Stage 2: sum the terms of each component and the squares of a.
	always_comb begin
		sumsq_c = '0;
		for (int k = 0; k < 4; k++) begin
			sumsq_c = sumsq_c + qau_pkg::SW'($unsigned(prod_s1[k][k]));
			acc_c[k] = '0;
			case (mode_s1)
				qau_pkg::MODE_MUL: begin
					for (int t = 0; t < 4; t++) begin
						if (qau_pkg::BNEG[k][t]) begin
							acc_c[k] = acc_c[k]
								- qau_pkg::AW'(prod_s1[t][qau_pkg::BSEL[k][t]]);
						end else begin
							acc_c[k] = acc_c[k]
								+ qau_pkg::AW'(prod_s1[t][qau_pkg::BSEL[k][t]]);
						end
					end
				end
				qau_pkg::MODE_SCALE: acc_c[k] = qau_pkg::AW'(prod_s1[k][k]);
				qau_pkg::MODE_CONJ,
				qau_pkg::MODE_ADD:   acc_c[k] = qau_pkg::AW'(lin_s1[k]);
				default:             acc_c[k] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			sumsq_s2 <= sumsq_c;
			for (int k = 0; k < 4; k++) begin
				acc_s2[k] <= acc_c[k];
				a_s2[k]   <= a_s1[k];
			end
		end
	end

	// Stage 3: rounding and saturation; normalise passes a on to the root.
	always_comb begin
		pay_c      = '0;
		pay_c.norm = (mode_s2 == qau_pkg::MODE_NORM);
		pay_c.zero = (sumsq_s2 == '0);
		rv_c       = '0;
		st_c       = '0;
		for (int k = 0; k < 4; k++) begin
			if (mode_s2 == qau_pkg::MODE_MUL || mode_s2 == qau_pkg::MODE_SCALE) begin
				rv_c = (acc_s2[k] + qau_pkg::RND) >>> qau_pkg::FW;
			end else begin
				rv_c = acc_s2[k];
			end
			st_c = qau_pkg::sat_wide(rv_c);
			if (pay_c.norm) begin
				pay_c.r[k] = a_s2[k];
			end else begin
				pay_c.r[k] = st_c.val;
				pay_c.ovf  = pay_c.ovf | st_c.ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[qau_pkg::S_SQ0]  <= pay_c;
			rem_s[qau_pkg::S_SQ0]  <= qau_pkg::QRW'(sumsq_s2);
			root_s[qau_pkg::S_SQ0] <= '0;
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar i = 0; i < qau_pkg::SQ_STEPS; i++) begin : g_sqrt
		localparam int ST = qau_pkg::S_SQ0 + 1 + i;
		localparam logic [qau_pkg::QRW-1:0] BITC =
			qau_pkg::QRW'(1) << (2 * (qau_pkg::SQ_STEPS - 1 - i));
		logic [qau_pkg::QRW-1:0] trial;
		logic                   ge;

		assign trial = root_s[ST-1] + BITC;
		assign ge    = rem_s[ST-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[ST]  <= pay_s[ST-1];
				rem_s[ST]  <= ge ? rem_s[ST-1] - trial : rem_s[ST-1];
				root_s[ST] <= ge ? (root_s[ST-1] >> 1) + BITC : root_s[ST-1] >> 1;
			end
		end
	end

	// Divider set-up: numerator 2|a|*2^28 + n over 2n rounds half away from zero.
	always_comb begin
		n_c = root_s[qau_pkg::S_PR-1][qau_pkg::NRW-1:0];
		for (int k = 0; k < 4; k++) begin
			mag_c[k] = pay_s[qau_pkg::S_PR-1].r[k][qau_pkg::DW-1]
				? qau_pkg::DW'(-pay_s[qau_pkg::S_PR-1].r[k])
				: qau_pkg::DW'(pay_s[qau_pkg::S_PR-1].r[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[qau_pkg::S_PR] <= pay_s[qau_pkg::S_PR-1];
			den_s[qau_pkg::S_PR] <= {n_c, 1'b0};
			for (int k = 0; k < 4; k++) begin
				num_s[qau_pkg::S_PR][k] <= {mag_c[k], {qau_pkg::QW{1'b0}}}
					+ qau_pkg::NW'(n_c);
				qt_s[qau_pkg::S_PR][k]  <= '0;
			end
		end
	end

	// Restoring division, one quotient bit per stage for all four lanes.
	for (genvar i = 0; i < qau_pkg::QW; i++) begin : g_div
		localparam int ST = qau_pkg::S_PR + 1 + i;
		localparam int QB = qau_pkg::QW - 1 - i;
		logic [qau_pkg::RW-1:0] dsh;
		logic [3:0]             ge;

		assign dsh = qau_pkg::RW'(den_s[ST-1]) << QB;
		always_comb begin
			for (int k = 0; k < 4; k++) begin
				ge[k] = qau_pkg::RW'(num_s[ST-1][k]) >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[ST] <= pay_s[ST-1];
				den_s[ST] <= den_s[ST-1];
				for (int k = 0; k < 4; k++) begin
					num_s[ST][k] <= ge[k]
						? qau_pkg::NW'(qau_pkg::RW'(num_s[ST-1][k]) - dsh)
						: num_s[ST-1][k];
					qt_s[ST][k] <= qt_s[ST-1][k] | (qau_pkg::QW'(ge[k]) << QB);
				end
			end
		end
	end

	// Output register: normalise results replace the carried values.
	always_comb begin
		out_c = pay_s[qau_pkg::LAT-1];
		if (out_c.norm) begin
			for (int k = 0; k < 4; k++) begin
				if (out_c.zero) begin
					out_c.r[k] = (k == 0) ? qau_pkg::ONE : '0;
				end else if (pay_s[qau_pkg::LAT-1].r[k][qau_pkg::DW-1]) begin
					out_c.r[k] = -qau_pkg::DW'(qt_s[qau_pkg::LAT-1][k]);
				end else begin
					out_c.r[k] = qau_pkg::DW'(qt_s[qau_pkg::LAT-1][k]);
				end
			end
		end else begin
			out_c.zero = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s67 <= out_c;
		end
	end

	assign rsp.valid     = vld_s[qau_pkg::LAT];
	assign rsp.r_w       = out_s67.r[0];
	assign rsp.r_x       = out_s67.r[1];
	assign rsp.r_y       = out_s67.r[2];
	assign rsp.r_z       = out_s67.r[3];
	assign rsp.overflow  = out_s67.ovf;
	assign rsp.zero_norm = out_s67.norm & out_s67.zero;

`ifndef SYNTH
	a_zero_norm_identity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_norm |-> rsp.r_w == qau_pkg::ONE && rsp.r_x == '0
		&& rsp.r_y == '0 && rsp.r_z == '0 && !rsp.overflow)
		else $error("Zero norm transaction did not return the identity.");
	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready == (!rsp.valid || rsp.ready))
		else $error("Command ready disagrees with the output stall.");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> vld_s[1])
		else $error("Accepted transaction did not enter the first stage.");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("Pipeline moved during a stall.");
`endif

endmodule
